// ===== rtl/sbd_pkg.sv =====
// Shared types, constants and register codes for the subband energy beat detector.
`default_nettype none
package sbd_pkg;

  localparam int SUBBANDS_DEF         = 32;
  localparam int BINS_PER_BAND_DEF    = 32;
  localparam int HISTORY_DEPTH_DEF    = 43;
  localparam int BEAT_QUEUE_DEPTH_DEF = 16;

  localparam int ITEM_FIFO_DEPTH = 4;

  localparam int RATIO_W  = 12;
  localparam int CUTOFF_W = 16;
  localparam int CFG_W    = 16;

  localparam logic [RATIO_W-1:0]  RATIO_RESET  = 12'd384;
  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'd1000;

  localparam logic CFG_ENERGY_RATIO = 1'b0;
  localparam logic CFG_BEAT_CUTOFF  = 1'b1;

  localparam logic [22:0] BPM_SCALE = 23'd6000000;
  localparam logic [19:0] BPM_MAX   = 20'd999999;

  typedef struct packed {
    logic signed [15:0] left_bin;
    logic signed [15:0] right_bin;
    logic [31:0]        time_ms;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  band_index;
    logic [31:0] instant_energy;
    logic [31:0] average_energy;
    logic        beat_now;
    logic        beat_onset;
    logic [4:0]  beats_queued;
    logic [19:0] bpm_centi;
    logic        bpm_valid;
    logic        frame_last;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/sbd_front.sv =====
// Front end: squares bin pairs, accumulates them and emits one item per closed subband.
`default_nettype none
module sbd_front import sbd_pkg::*; #(
  parameter int SUBBANDS      = SUBBANDS_DEF,
  parameter int BINS_PER_BAND = BINS_PER_BAND_DEF,
  parameter int ITEM_W        = $clog2(SUBBANDS) + 32 + $clog2(BINS_PER_BAND) + 33
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  input  wire logic              fifo_full,
  output logic                   fifo_push,
  output logic [ITEM_W-1:0]      fifo_wdata
);

  localparam int BAND_W = $clog2(SUBBANDS);
  localparam int BIN_W  = (BINS_PER_BAND > 1) ? $clog2(BINS_PER_BAND) : 1;
  localparam int ACC_W  = 32 + $clog2(BINS_PER_BAND);

  logic [BIN_W-1:0]  bin_r;
  logic [BAND_W-1:0] band_r;
  logic [ACC_W-1:0]  acc_r;
  logic              s1_valid_r;
  logic [31:0]       s1_sq_r;
  logic [31:0]       s1_time_r;
  logic              s1_close_r;
  logic [BAND_W-1:0] s1_band_r;
  logic              s1_last_r;

  logic signed [31:0] lsq;
  logic signed [31:0] rsq;
  logic               in_accept;
  logic               close;
  logic               s1_go;
  logic [ACC_W-1:0]   acc_sum;

  assign lsq       = in_data.left_bin * in_data.left_bin;
  assign rsq       = in_data.right_bin * in_data.right_bin;
  assign close     = (bin_r == BIN_W'(BINS_PER_BAND - 1));
  assign s1_go     = s1_valid_r && !(s1_close_r && fifo_full);
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign acc_sum   = acc_r + ACC_W'(s1_sq_r);

  assign fifo_push  = s1_go && s1_close_r;
  assign fifo_wdata = {s1_band_r, acc_sum, s1_time_r, s1_last_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r      <= '0;
      band_r     <= '0;
      acc_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
        bin_r      <= close ? '0 : bin_r + 1'b1;
        if (close) begin
          band_r <= (band_r == BAND_W'(SUBBANDS - 1)) ? '0 : band_r + 1'b1;
        end
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        acc_r <= s1_close_r ? '0 : acc_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sq_r    <= $unsigned(lsq) + $unsigned(rsq);
      s1_time_r  <= in_data.time_ms;
      s1_close_r <= close;
      s1_band_r  <= band_r;
      s1_last_r  <= close && (band_r == BAND_W'(SUBBANDS - 1));
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbd_fifo.sv =====
// Small queue of closed subband items between the front and back ends.
`default_nettype none
module sbd_fifo import sbd_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = ITEM_FIFO_DEPTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty,
  output logic              full
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [W-1:0]     store [DEPTH];
  logic [PTR_W-1:0] wr_r;
  logic [PTR_W-1:0] rd_r;
  logic [PTR_W:0]   cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (PTR_W+1)'(DEPTH));
  assign rdata = store[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module sbd_div #(
  parameter int DIV_W = 40,
  parameter int DVS_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial    = {rem_r, q_r[DIV_W-1]};
  assign fits     = (trial >= {1'b0, dvs_r});
  assign done     = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
      q_r   <= {q_r[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sbd_back.sv =====
// Back end: history average, beat decision, beat time queue and tempo for each subband.
`default_nettype none
module sbd_back import sbd_pkg::*; #(
  parameter int SUBBANDS         = SUBBANDS_DEF,
  parameter int BINS_PER_BAND    = BINS_PER_BAND_DEF,
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BEAT_QUEUE_DEPTH = BEAT_QUEUE_DEPTH_DEF,
  parameter int ITEM_W           = $clog2(SUBBANDS) + 32 + $clog2(BINS_PER_BAND) + 33
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_empty,
  input  wire logic [ITEM_W-1:0]   item_data,
  output logic                     item_pop,
  input  wire logic [RATIO_W-1:0]  energy_ratio,
  input  wire logic [CUTOFF_W-1:0] beat_cutoff_ms,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output out_item_t                out_data
);

  localparam int BAND_W  = $clog2(SUBBANDS);
  localparam int ACC_W   = 32 + $clog2(BINS_PER_BAND);
  localparam int SUM_W   = 33 + $clog2(HISTORY_DEPTH);
  localparam int HSLOT_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int QP_W    = $clog2(BEAT_QUEUE_DEPTH);
  localparam int QC_W    = $clog2(BEAT_QUEUE_DEPTH + 1);
  localparam int NUM_W   = 23 + QC_W;
  localparam int DIV_A   = (ACC_W > SUM_W) ? ACC_W : SUM_W;
  localparam int DIV_W   = (DIV_A > NUM_W) ? DIV_A : NUM_W;
  localparam int DVS_W   = 32;
  localparam int HADDR_W = $clog2(SUBBANDS * HISTORY_DEPTH);
  localparam int QADDR_W = $clog2(SUBBANDS * BEAT_QUEUE_DEPTH);
  localparam int BS_W    = SUM_W + QP_W + QC_W + 1;

  // The mean over a subband is a multiply by a rounded-up reciprocal, done in four
  // partial products; it is exact for every accumulator value.
  localparam int RS      = ACC_W + $clog2(BINS_PER_BAND);
  localparam int RM_W    = ACC_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << RS) + 64'(BINS_PER_BAND) - 64'd1) / 64'(BINS_PER_BAND);
  localparam logic [RM_W-1:0] RECIP_V = RM_W'(RECIP);
  localparam int AL_W    = (ACC_W + 1) / 2;
  localparam int ML_W    = (RM_W + 1) / 2;
  localparam int PR_W    = ACC_W + RM_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_DINST = 4'd2;
  localparam logic [3:0] ST_HIST  = 4'd3;
  localparam logic [3:0] ST_DAVG  = 4'd4;
  localparam logic [3:0] ST_MUL   = 4'd5;
  localparam logic [3:0] ST_BEAT  = 4'd6;
  localparam logic [3:0] ST_PRD   = 4'd7;
  localparam logic [3:0] ST_PCHK  = 4'd8;
  localparam logic [3:0] ST_SPAN0 = 4'd9;
  localparam logic [3:0] ST_SPAN1 = 4'd10;
  localparam logic [3:0] ST_SPAN2 = 4'd11;
  localparam logic [3:0] ST_DBPM  = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  function automatic logic [QP_W-1:0] wrap_add(input logic [QP_W-1:0] a,
                                               input logic [QP_W-1:0] b);
    logic [QP_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (QP_W+1)'(BEAT_QUEUE_DEPTH)) begin
      s = s - (QP_W+1)'(BEAT_QUEUE_DEPTH);
    end
    return s[QP_W-1:0];
  endfunction

  logic [3:0]         state_r;
  logic [BAND_W-1:0]  band_r;
  logic [ACC_W-1:0]   acc_r;
  logic [31:0]        time_r;
  logic               last_r;
  logic [31:0]        inst_r;
  logic [31:0]        avg_r;
  logic [43:0]        prod_r;
  logic               beat_r;
  logic               onset_r;
  logic [SUM_W-1:0]   sum_r;
  logic [QP_W-1:0]    head_r;
  logic [QC_W-1:0]    cnt_r;
  logic               seen_r;
  logic [31:0]        first_r;
  logic [19:0]        bpm_r;
  logic [FILL_W-1:0]  fill_r;
  logic [HSLOT_W-1:0] slot_r;
  logic [SUBBANDS-1:0] bvalid_r;
  logic               out_valid_r;
  out_item_t          out_data_r;
  logic [1:0]         mi_r;
  logic [PR_W-1:0]    rp_r;

  logic [31:0]        hmem [SUBBANDS * HISTORY_DEPTH];
  logic [31:0]        hist_rd_r;
  logic [BS_W-1:0]    bmem [SUBBANDS];
  logic [BS_W-1:0]    bs_rd_r;
  logic [31:0]        qmem [SUBBANDS * BEAT_QUEUE_DEPTH];
  logic [31:0]        q_rd_r;

  logic [BAND_W-1:0]  i_band;
  logic [ACC_W-1:0]   i_acc;
  logic [31:0]        i_time;
  logic               i_last;
  logic [HADDR_W-1:0] haddr;
  logic [QADDR_W-1:0] qbase;
  logic [QADDR_W-1:0] q_ra;
  logic [QADDR_W-1:0] q_wa;
  logic               q_we;
  logic               h_we;
  logic               b_we;
  logic               hist_full;
  logic [FILL_W-1:0]  fill_eff;
  logic [SUM_W-1:0]   bs_sum;
  logic [QP_W-1:0]    bs_head;
  logic [QC_W-1:0]    bs_cnt;
  logic               bs_seen;
  logic [SUM_W-1:0]   sum_base;
  logic [SUM_W-1:0]   sum_nxt;
  logic               beat;
  logic               q_full;
  logic [QP_W-1:0]    h1;
  logic [QP_W-1:0]    c1;
  logic [31:0]        age;
  logic [31:0]        span;
  logic [NUM_W-1:0]   bpm_num;
  logic               out_free;
  logic               div_start;
  logic [DIV_W-1:0]   div_dividend;
  logic [DVS_W-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [BAND_W+4:0]  band_ext;
  logic [QC_W+4:0]    cnt_ext;
  logic [AL_W-1:0]    m_a;
  logic [ML_W-1:0]    m_b;
  logic [AL_W+ML_W-1:0] m_pp;
  logic [PR_W-1:0]    m_sh;
  logic [PR_W-1:0]    rp_sum;

  assign {i_band, i_acc, i_time, i_last} = item_data;
  assign {bs_sum, bs_head, bs_cnt, bs_seen} = bvalid_r[band_r] ? bs_rd_r : '0;

  assign haddr     = HADDR_W'(band_r * HISTORY_DEPTH) + HADDR_W'(slot_r);
  assign qbase     = QADDR_W'(band_r * BEAT_QUEUE_DEPTH);
  assign hist_full = (fill_r == FILL_W'(HISTORY_DEPTH));
  assign fill_eff  = hist_full ? FILL_W'(HISTORY_DEPTH) : fill_r + 1'b1;
  assign sum_base  = bs_sum - (hist_full ? SUM_W'(hist_rd_r) : '0);
  assign sum_nxt   = sum_base + SUM_W'(inst_r);
  assign beat      = ({4'd0, inst_r, 8'd0} > prod_r);
  assign q_full    = (cnt_r == QC_W'(BEAT_QUEUE_DEPTH));
  assign h1        = q_full ? wrap_add(head_r, QP_W'(1)) : head_r;
  assign c1        = q_full ? QP_W'(BEAT_QUEUE_DEPTH - 1) : QP_W'(cnt_r);
  assign age       = time_r - q_rd_r;
  assign span      = q_rd_r - first_r;
  assign bpm_num   = NUM_W'(BPM_SCALE) * NUM_W'(cnt_r - 1'b1);
  assign out_free  = !out_valid_r || !out_stall;
  assign band_ext  = {5'd0, band_r};
  assign cnt_ext   = {5'd0, cnt_r};

  assign m_a    = mi_r[1] ? AL_W'(acc_r >> AL_W) : acc_r[AL_W-1:0];
  assign m_b    = mi_r[0] ? ML_W'(RECIP_V >> ML_W) : RECIP_V[ML_W-1:0];
  assign m_pp   = m_a * m_b;
  assign rp_sum = rp_r + m_sh;

  always_comb begin
    unique case (mi_r)
      2'd0: m_sh = PR_W'(m_pp);
      2'd1: m_sh = PR_W'(m_pp) << ML_W;
      2'd2: m_sh = PR_W'(m_pp) << AL_W;
      2'd3: m_sh = PR_W'(m_pp) << (AL_W + ML_W);
    endcase
  end

  assign item_pop  = (state_r == ST_IDLE) && !item_empty;
  assign h_we      = (state_r == ST_HIST);
  assign q_we      = (state_r == ST_BEAT) && beat && !seen_r;
  assign q_wa      = qbase + QADDR_W'(wrap_add(h1, c1));
  assign b_we      = (state_r == ST_OUT) && out_free;
  assign q_ra      = (state_r == ST_SPAN1) ?
                     qbase + QADDR_W'(wrap_add(head_r, QP_W'(cnt_r - 1'b1))) :
                     qbase + QADDR_W'(head_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state_r)
      ST_HIST: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sum_nxt);
        div_divisor  = DVS_W'(fill_eff);
      end
      ST_SPAN2: begin
        div_start    = (span != '0);
        div_dividend = DIV_W'(bpm_num);
        div_divisor  = span;
      end
      default: begin
      end
    endcase
  end

  sbd_div #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[haddr] <= inst_r;
    end
    hist_rd_r <= hmem[haddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[band_r] <= {sum_r, head_r, cnt_r, seen_r};
    end
    bs_rd_r <= bmem[band_r];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[q_wa] <= time_r;
    end
    q_rd_r <= qmem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      slot_r      <= '0;
      bvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_we) begin
        out_valid_r      <= 1'b1;
        bvalid_r[band_r] <= 1'b1;
        if (last_r) begin
          slot_r <= (slot_r == HSLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          if (!hist_full) begin
            fill_r <= fill_r + 1'b1;
          end
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE:  if (!item_empty) state_r <= ST_RD;
        ST_RD:    state_r <= ST_DINST;
        ST_DINST: if (mi_r == 2'd3) state_r <= ST_HIST;
        ST_HIST:  state_r <= ST_DAVG;
        ST_DAVG:  if (div_done) state_r <= ST_MUL;
        ST_MUL:   state_r <= ST_BEAT;
        ST_BEAT:  state_r <= (beat && !seen_r) ? ST_PRD : ST_SPAN0;
        ST_PRD:   state_r <= ST_PCHK;
        ST_PCHK: begin
          if ((cnt_r != '0) && (age > 32'(beat_cutoff_ms))) begin
            state_r <= ST_PRD;
          end else begin
            state_r <= ST_SPAN0;
          end
        end
        ST_SPAN0: state_r <= (cnt_r >= QC_W'(2)) ? ST_SPAN1 : ST_OUT;
        ST_SPAN1: state_r <= ST_SPAN2;
        ST_SPAN2: state_r <= (span == '0) ? ST_OUT : ST_DBPM;
        ST_DBPM:  if (div_done) state_r <= ST_OUT;
        ST_OUT:   if (out_free) state_r <= ST_IDLE;
        default:  state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        band_r <= i_band;
        acc_r  <= i_acc;
        time_r <= i_time;
        last_r <= i_last;
        rp_r   <= '0;
        mi_r   <= '0;
      end
      ST_RD: begin
        rp_r <= rp_sum;
        mi_r <= mi_r + 1'b1;
      end
      ST_DINST: begin
        rp_r <= rp_sum;
        mi_r <= mi_r + 1'b1;
        if (mi_r == 2'd3) begin
          inst_r <= 32'(rp_sum >> RS);
        end
      end
      ST_HIST: begin
        sum_r  <= sum_nxt;
        head_r <= bs_head;
        cnt_r  <= bs_cnt;
        seen_r <= bs_seen;
      end
      ST_DAVG: begin
        avg_r <= div_q[31:0];
      end
      ST_MUL: begin
        prod_r <= 44'(energy_ratio) * 44'(avg_r);
      end
      ST_BEAT: begin
        beat_r  <= beat;
        onset_r <= beat && !seen_r;
        if (beat && !seen_r) begin
          seen_r <= 1'b1;
          head_r <= h1;
          cnt_r  <= QC_W'(c1) + 1'b1;
        end else if (!beat) begin
          seen_r <= 1'b0;
        end
      end
      ST_PCHK: begin
        if ((cnt_r != '0) && (age > 32'(beat_cutoff_ms))) begin
          head_r <= wrap_add(head_r, QP_W'(1));
          cnt_r  <= cnt_r - 1'b1;
        end
      end
      ST_SPAN0: begin
        bpm_r <= '0;
      end
      ST_SPAN1: begin
        first_r <= q_rd_r;
      end
      ST_SPAN2: begin
        bpm_r <= BPM_MAX;
      end
      ST_DBPM: begin
        bpm_r <= (div_q > DIV_W'(BPM_MAX)) ? BPM_MAX : div_q[19:0];
      end
      ST_OUT: begin
        if (out_free) begin
          out_data_r.band_index     <= band_ext[4:0];
          out_data_r.instant_energy <= inst_r;
          out_data_r.average_energy <= avg_r;
          out_data_r.beat_now       <= beat_r;
          out_data_r.beat_onset     <= onset_r;
          out_data_r.beats_queued   <= cnt_ext[4:0];
          out_data_r.bpm_centi      <= bpm_r;
          out_data_r.bpm_valid      <= (cnt_r >= QC_W'(2));
          out_data_r.frame_last     <= last_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/subband_energy_beat_detector_top.sv =====
// Top level of the subband energy beat detector: configuration registers and the two ends.
//
//   Channel  Direction  Handshake        Payload
//   in_      input      valid / stall    in_item_t, one spectrum bin pair and time
//   out_     output     valid / stall    out_item_t, one result per closed subband
//   cfg_     input      write enable     register index and 16-bit data
//
// The front end takes one bin per cycle while the item queue has room and closes a subband
// every BINS_PER_BAND bins. The back end then works through each subband alone and takes no new
// item until its result is registered; most of its time goes to the bit-serial divider for the
// average and the tempo, and an onset and each pruned beat time add a read and a check step.
// A four-entry queue lets the front end run ahead; it stalls the input once that fills.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// A stalled result holds in the output register while the back end works on the next subband.
`default_nettype none
module subband_energy_beat_detector_top import sbd_pkg::*; #(
  parameter int SUBBANDS         = SUBBANDS_DEF,
  parameter int BINS_PER_BAND    = BINS_PER_BAND_DEF,
  parameter int HISTORY_DEPTH    = HISTORY_DEPTH_DEF,
  parameter int BEAT_QUEUE_DEPTH = BEAT_QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int ITEM_W = $clog2(SUBBANDS) + 32 + $clog2(BINS_PER_BAND) + 33;

  logic [RATIO_W-1:0]  ratio_r;
  logic [CUTOFF_W-1:0] cutoff_r;
  logic                fifo_full;
  logic                fifo_empty;
  logic                fifo_push;
  logic                fifo_pop;
  logic [ITEM_W-1:0]   fifo_wdata;
  logic [ITEM_W-1:0]   fifo_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RATIO_RESET;
      cutoff_r <= CUTOFF_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENERGY_RATIO: ratio_r  <= cfg_data[RATIO_W-1:0];
        CFG_BEAT_CUTOFF:  cutoff_r <= cfg_data[CUTOFF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  sbd_front #(
    .SUBBANDS      (SUBBANDS),
    .BINS_PER_BAND (BINS_PER_BAND),
    .ITEM_W        (ITEM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .fifo_full  (fifo_full),
    .fifo_push  (fifo_push),
    .fifo_wdata (fifo_wdata)
  );

  sbd_fifo #(
    .W     (ITEM_W),
    .DEPTH (ITEM_FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty),
    .full  (fifo_full)
  );

  sbd_back #(
    .SUBBANDS         (SUBBANDS),
    .BINS_PER_BAND    (BINS_PER_BAND),
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BEAT_QUEUE_DEPTH (BEAT_QUEUE_DEPTH),
    .ITEM_W           (ITEM_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .item_empty     (fifo_empty),
    .item_data      (fifo_rdata),
    .item_pop       (fifo_pop),
    .energy_ratio   (ratio_r),
    .beat_cutoff_ms (cutoff_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/sbd_checker.sv =====
// Port-level checks on the result channel of the beat detector, bound to the top level.
`default_nettype none
module sbd_checker import sbd_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_bpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.bpm_valid |-> out_data.bpm_centi == 20'd0)
    else $error("tempo reported without two queued beats");

  a_bpm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.bpm_valid |-> out_data.beats_queued >= 5'd2)
    else $error("tempo valid with fewer than two beats");

  a_onset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beat_onset |-> out_data.beat_now && out_data.beats_queued != 5'd0)
    else $error("onset without a beat or a queued time");

  a_bpm_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.bpm_centi <= BPM_MAX)
    else $error("tempo above saturation limit");

endmodule

bind subband_energy_beat_detector_top sbd_checker u_sbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== tb/subband_energy_beat_detector_top_test.sv =====
// Self-checking testbench for the subband energy beat detector: random bins, scoreboard check.
`timescale 1ns / 100ps
`default_nettype none
module subband_energy_beat_detector_top_test;
  import sbd_pkg::*;

  localparam int NB = SUBBANDS_DEF;
  localparam int BPB = BINS_PER_BAND_DEF;
  localparam int HD = HISTORY_DEPTH_DEF;
  localparam int QD = BEAT_QUEUE_DEPTH_DEF;
  localparam int FRAME_BINS = NB * BPB;
  localparam longint CYCLE_LIMIT = 2000000;

  class band_scoreboard;
    logic [11:0] ratio;
    logic [15:0] cutoff;
    longint unsigned acc;
    int pos;
    logic [31:0] hist [NB*HD];
    longint unsigned hsum [NB];
    int fill, slot;
    bit seen [NB];
    logic [31:0] times [NB*QD];
    int qhead [NB], qcount [NB];
    out_item_t pending [$];
    int errors, results, onsets, bpm_seen;

    function new();
      ratio = RATIO_RESET;
      cutoff = CUTOFF_RESET;
      acc = 0; pos = 0; fill = 0; slot = 0;
      errors = 0; results = 0; onsets = 0; bpm_seen = 0;
      foreach (hsum[i]) begin
        hsum[i] = 0; seen[i] = 0; qhead[i] = 0; qcount[i] = 0;
      end
    endfunction

    function void note_input(in_item_t it);
      longint signed l, r;
      longint unsigned inst, avg, bpm;
      int band, fe, si, n;
      bit beat, onset;
      logic [31:0] span;
      out_item_t o;
      l = it.left_bin;
      r = it.right_bin;
      acc += longint'(l * l) + longint'(r * r);
      if (pos % BPB != BPB - 1) begin
        pos = (pos + 1) % FRAME_BINS;
        return;
      end
      band = pos / BPB;
      pos = (pos + 1) % FRAME_BINS;
      inst = acc / BPB;
      acc = 0;
      si = band * HD + slot;
      if (fill >= HD) hsum[band] -= hist[si];
      hist[si] = inst[31:0];
      hsum[band] += inst;
      fe = (fill + 1 > HD) ? HD : fill + 1;
      avg = hsum[band] / fe;
      beat = (inst * 256) > (longint'(ratio) * avg);
      onset = 0;
      if (beat) begin
        if (!seen[band]) begin
          seen[band] = 1;
          onset = 1;
          if (qcount[band] >= QD) begin
            qhead[band] = (qhead[band] + 1) % QD;
            qcount[band] = QD - 1;
          end
          times[band*QD + (qhead[band] + qcount[band]) % QD] = it.time_ms;
          qcount[band]++;
          while (qcount[band] > 0 &&
                 (it.time_ms - times[band*QD + qhead[band]]) > {16'd0, cutoff}) begin
            qhead[band] = (qhead[band] + 1) % QD;
            qcount[band]--;
          end
        end
      end else seen[band] = 0;
      n = qcount[band];
      bpm = 0;
      if (n >= 2) begin
        span = times[band*QD + (qhead[band] + n - 1) % QD] - times[band*QD + qhead[band]];
        if (span == 0) bpm = 999999;
        else begin
          bpm = (64'd6000000 * (n - 1)) / span;
          if (bpm > 999999) bpm = 999999;
        end
      end
      if (band == NB - 1) begin
        slot = (slot + 1) % HD;
        if (fill < HD) fill++;
      end
      o.band_index = band[4:0];
      o.instant_energy = inst[31:0];
      o.average_energy = avg[31:0];
      o.beat_now = beat;
      o.beat_onset = onset;
      o.beats_queued = n[4:0];
      o.bpm_centi = bpm[19:0];
      o.bpm_valid = (n >= 2);
      o.frame_last = (band == NB - 1);
      pending = {pending, o};
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result for band %0d", a.band_index);
        errors++;
        return;
      end
      e = pending.pop_front();
      results++;
      if (e.beat_onset) onsets++;
      if (e.bpm_valid) bpm_seen++;
      if (a.band_index !== e.band_index) begin
        $error("band_index exp %0d got %0d", e.band_index, a.band_index); errors++;
      end
      if (a.instant_energy !== e.instant_energy) begin
        $error("instant_energy exp %0d got %0d", e.instant_energy, a.instant_energy); errors++;
      end
      if (a.average_energy !== e.average_energy) begin
        $error("average_energy exp %0d got %0d", e.average_energy, a.average_energy); errors++;
      end
      if (a.beat_now !== e.beat_now) begin
        $error("beat_now exp %0d got %0d", e.beat_now, a.beat_now); errors++;
      end
      if (a.beat_onset !== e.beat_onset) begin
        $error("beat_onset exp %0d got %0d", e.beat_onset, a.beat_onset); errors++;
      end
      if (a.beats_queued !== e.beats_queued) begin
        $error("beats_queued exp %0d got %0d", e.beats_queued, a.beats_queued); errors++;
      end
      if (a.bpm_centi !== e.bpm_centi) begin
        $error("bpm_centi exp %0d got %0d", e.bpm_centi, a.bpm_centi); errors++;
      end
      if (a.bpm_valid !== e.bpm_valid) begin
        $error("bpm_valid exp %0d got %0d", e.bpm_valid, a.bpm_valid); errors++;
      end
      if (a.frame_last !== e.frame_last) begin
        $error("frame_last exp %0d got %0d", e.frame_last, a.frame_last); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_data;
  logic cfg_we = 0;
  logic cfg_index = CFG_ENERGY_RATIO;
  logic [CFG_W-1:0] cfg_data = '0;

  band_scoreboard sb;
  longint cycles = 0;
  bit calm = 0;
  bit hold_long = 0;
  logic [31:0] now_ms = 0;

  subband_energy_beat_detector_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin : receiver
    int k, n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        for (k = 0; k < 800; k++) @(posedge clk);
        hold_long = 0;
        out_stall <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 15);
        out_stall <= 1;
        for (k = 0; k < n; k++) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_bin(logic [15:0] l, logic [15:0] r);
    int k, n;
    if (!calm && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 15);
      in_valid <= 0;
      for (k = 0; k < n; k++) @(posedge clk);
    end
    in_valid <= 1;
    in_data.left_bin <= l;
    in_data.right_bin <= r;
    in_data.time_ms <= now_ms;
    do @(posedge clk); while (in_stall);
    sb.note_input('{left_bin: l, right_bin: r, time_ms: now_ms});
    now_ms = now_ms + $urandom_range(0, 3);
  endtask

  task automatic send_bins(int count, int mode);
    int b;
    logic [15:0] amp;
    for (b = 0; b < count; b++) begin
      if (mode == 2 && b % BPB == 0) now_ms = now_ms + $urandom_range(0, 900);
      if (mode == 0) send_bin(16'($urandom), 16'($urandom));
      else if (mode == 3) send_bin(16'h8000, 16'h8000);
      else begin
        amp = ($urandom_range(0, 3) == 0) ? 16'd30000 : 16'(300 + b / BPB);
        send_bin($urandom_range(0, 1) ? amp : -amp, 16'($urandom_range(0, amp)));
      end
    end
  endtask

  task automatic drain();
    int k;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    for (k = 0; k < 200; k++) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_ENERGY_RATIO) sb.ratio = val[11:0];
    else sb.cutoff = val;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_bins(32, 3);
    drain();
    send_bins(64, 0);
    drain();
    write_reg(CFG_ENERGY_RATIO, 16'd0);
    write_reg(CFG_BEAT_CUTOFF, 16'd0);
    send_bins(128, 1);
    drain();
    write_reg(CFG_ENERGY_RATIO, 16'd4095);
    write_reg(CFG_BEAT_CUTOFF, 16'hFFFF);
    now_ms = 32'hFFFF_FFC0;
    send_bins(64, 1);
    drain();
    write_reg(CFG_ENERGY_RATIO, 16'd300);
    write_reg(CFG_BEAT_CUTOFF, 16'd3000);
    hold_long = 1;
    send_bins(256, 1);
    drain();
    write_reg(CFG_ENERGY_RATIO, 16'd384);
    write_reg(CFG_BEAT_CUTOFF, 16'd1000);
    send_bins(128, 2);
    calm = 1;
    send_bins(96, 0);
    drain();
    $display("covered %0d subband results, %0d onsets, %0d with tempo",
             sb.results, sb.onsets, sb.bpm_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/sbd_pkg.sv
rtl/sbd_front.sv
rtl/sbd_fifo.sv
rtl/sbd_div.sv
rtl/sbd_back.sv
rtl/subband_energy_beat_detector_top.sv
rtl/sbd_checker.sv
tb/subband_energy_beat_detector_top_test.sv
